>>> rtl/core/btlv_pkg.sv
// Shared types and constants for the BER TLV header parser.
// Depends on nothing; every other file in rtl/core imports it.
package btlv_pkg;

  // Fixed widths of the result fields
  localparam int unsigned TAG_W = 30;
  localparam int unsigned LEN_OUT_W = 64;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_LENGTH_BYTES_DEF = 8;
  localparam int unsigned TAG_BITS_DEF = 30;

  // Octet codes
  localparam logic [4:0] TAG_ESCAPE = 5'h1f;  // low five identifier bits: multi-byte tag
  localparam logic [7:0] LEN_INDEF = 8'h80;   // first length octet: indefinite form

  typedef enum logic [1:0] {
    PH_IDENT   = 2'd0,
    PH_TAGCONT = 2'd1,
    PH_LEN0    = 2'd2,
    PH_LENLONG = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TAG_WIDE = 2'd1,
    ST_LEN_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0]     tag_number;
    logic [1:0]           tag_class;
    logic                 constructed;
    logic [LEN_OUT_W-1:0] content_length;
    logic                 is_indefinite;
    status_t              status;
  } result_t;

endpackage

>>> rtl/core/btlv_decoder.sv
// Header decode state machine: identifier, tag continuation and length octets.
// Depends on btlv_pkg for phase, status and result types.
module btlv_decoder #(
  parameter int unsigned MAX_LENGTH_BYTES = btlv_pkg::MAX_LENGTH_BYTES_DEF,
  parameter int unsigned TAG_BITS = btlv_pkg::TAG_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        header_byte,
  output logic              res_valid,
  output btlv_pkg::result_t res
);
  import btlv_pkg::*;

  localparam int unsigned LEN_W = 8 * MAX_LENGTH_BYTES;
  localparam int unsigned CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

  phase_t              phase, phase_next;
  logic [TAG_BITS-1:0] tag_accum, tag_accum_next;
  logic [1:0]          class_held, class_held_next;
  logic                constructed_held, constructed_held_next;
  logic                tag_overflow, tag_overflow_next;
  logic [LEN_W-1:0]    length_accum, length_accum_next;
  logic [CNT_W-1:0]    length_bytes_left, length_bytes_left_next;

  logic [TAG_BITS-1:0] tag_shift;
  logic [LEN_W-1:0]    len_shift;
  logic                len_of_len_bad;
  logic                last_len_byte;
  status_t             ok_status;

  assign tag_shift      = TAG_BITS'({tag_accum, header_byte[6:0]});
  assign len_shift      = LEN_W'({length_accum, header_byte});
  assign len_of_len_bad = 32'(header_byte[6:0]) > MAX_LENGTH_BYTES;
  assign last_len_byte  = length_bytes_left <= CNT_W'(1);
  assign ok_status      = tag_overflow ? ST_TAG_WIDE : ST_OK;

  // Next state
  always_comb begin
    phase_next             = phase;
    tag_accum_next         = tag_accum;
    class_held_next        = class_held;
    constructed_held_next  = constructed_held;
    tag_overflow_next      = tag_overflow;
    length_accum_next      = length_accum;
    length_bytes_left_next = length_bytes_left;
    if (step) begin
      case (phase)
        PH_IDENT: begin
          class_held_next       = header_byte[7:6];
          constructed_held_next = header_byte[5];
          tag_overflow_next     = 1'b0;
          if (header_byte[4:0] == TAG_ESCAPE) begin
            tag_accum_next = '0;
            phase_next     = PH_TAGCONT;
          end else begin
            tag_accum_next = TAG_BITS'(header_byte[4:0]);
            phase_next     = PH_LEN0;
          end
        end
        PH_TAGCONT: begin
          // flag any set bit that the shift pushes out of the tag
          if (tag_accum[TAG_BITS-1 -: 7] != 7'd0) begin
            tag_overflow_next = 1'b1;
          end
          tag_accum_next = tag_shift;
          if (!header_byte[7]) begin
            phase_next = PH_LEN0;
          end
        end
        PH_LEN0: begin
          if (!header_byte[7] || header_byte == LEN_INDEF || len_of_len_bad) begin
            phase_next             = PH_IDENT;
            length_bytes_left_next = '0;
          end else begin
            length_accum_next      = '0;
            length_bytes_left_next = CNT_W'(header_byte[6:0]);
            phase_next             = PH_LENLONG;
          end
        end
        PH_LENLONG: begin
          length_accum_next = len_shift;
          if (last_len_byte) begin
            phase_next             = PH_IDENT;
            length_bytes_left_next = '0;
          end else begin
            length_bytes_left_next = length_bytes_left - CNT_W'(1);
          end
        end
        default: begin
          phase_next = PH_IDENT;
        end
      endcase
    end
  end

  // Result of the current byte
  always_comb begin
    res_valid          = 1'b0;
    res.tag_number     = TAG_W'(tag_accum);
    res.tag_class      = class_held;
    res.constructed    = constructed_held;
    res.content_length = '0;
    res.is_indefinite  = 1'b0;
    res.status         = ok_status;
    case (phase)
      PH_LEN0: begin
        if (!header_byte[7]) begin
          res_valid          = step;
          res.content_length = LEN_OUT_W'(header_byte);
        end else if (header_byte == LEN_INDEF) begin
          res_valid          = step;
          res.content_length = '1;
          res.is_indefinite  = 1'b1;
        end else if (len_of_len_bad) begin
          res_valid  = step;
          res.status = ST_LEN_LONG;
        end
      end
      PH_LENLONG: begin
        res_valid          = step && last_len_byte;
        res.content_length = LEN_OUT_W'(len_shift);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDENT;
      tag_accum         <= '0;
      class_held        <= '0;
      constructed_held  <= 1'b0;
      tag_overflow      <= 1'b0;
      length_accum      <= '0;
      length_bytes_left <= '0;
    end else begin
      phase             <= phase_next;
      tag_accum         <= tag_accum_next;
      class_held        <= class_held_next;
      constructed_held  <= constructed_held_next;
      tag_overflow      <= tag_overflow_next;
      length_accum      <= length_accum_next;
      length_bytes_left <= length_bytes_left_next;
    end
  end

endmodule

>>> rtl/core/btlv_out_reg.sv
// Result register: holds one decoded header until the receiver takes it.
// Depends on btlv_pkg for the result struct.
module btlv_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  btlv_pkg::result_t load_data,
  input  logic              stall,
  output logic              valid,
  output btlv_pkg::result_t data
);
  import btlv_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

>>> rtl/core/ber_tlv_header_parser.sv
// Top level of the BER TLV header parser: input register, decoder, result register.
// Depends on btlv_pkg, btlv_decoder and btlv_out_reg.
//
// Usage:
//   Feed identifier and length octets of consecutive TLV headers, one per
//   request, on the input channel (in_valid / in_stall / header_byte).
//   Content octets must not be sent: after the last length octet the block
//   expects the next identifier octet.
//   One result request per complete header leaves on the output channel
//   (out_valid / out_stall and the result fields). A first length octet
//   with more length bytes than MAX_LENGTH_BYTES ends the header at once
//   with status 2; the length bytes it announces are not consumed.
// Timing:
//   Each byte is held in the input register once its request is taken,
//   decoded from there by the decoder, and a result it completes is loaded
//   into the result register that drives out_valid and the result ports.
//   One byte per cycle sustained unless a waiting result is stalled; the decode
//   is a single pass of shift-or and compare logic between those two registers.
// Stalls and reset:
//   While the receiver stalls a waiting result, the input register holds
//   one byte and then in_stall rises; no byte or result is dropped.
//   Reset clears both valid flags and returns the decoder to expecting an
//   identifier octet.
module ber_tlv_header_parser #(
  parameter int unsigned MAX_LENGTH_BYTES = btlv_pkg::MAX_LENGTH_BYTES_DEF,
  parameter int unsigned TAG_BITS = btlv_pkg::TAG_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       header_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [btlv_pkg::TAG_W-1:0]       tag_number,
  output logic [1:0]                       tag_class,
  output logic                             constructed,
  output logic [btlv_pkg::LEN_OUT_W-1:0]   content_length,
  output logic                             is_indefinite,
  output logic [1:0]                       status
);
  import btlv_pkg::*;

  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_take;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  // Advance the held byte whenever the result slot is empty or drains now
  assign step     = in_q_valid && !(out_valid && out_stall);
  assign in_stall = in_q_valid && !step;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (step) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_byte <= header_byte;
    end
  end

  btlv_decoder #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES),
    .TAG_BITS(TAG_BITS)
  ) u_decoder (
    .clk(clk),
    .rst(rst),
    .step(step),
    .header_byte(in_q_byte),
    .res_valid(res_valid),
    .res(res)
  );

  btlv_out_reg u_out_reg (
    .clk(clk),
    .rst(rst),
    .load(res_valid),
    .load_data(res),
    .stall(out_stall),
    .valid(out_valid),
    .data(out_data)
  );

  assign tag_number     = out_data.tag_number;
  assign tag_class      = out_data.tag_class;
  assign constructed    = out_data.constructed;
  assign content_length = out_data.content_length;
  assign is_indefinite  = out_data.is_indefinite;
  assign status         = out_data.status;

  // A new result never overwrites one the receiver is still stalling
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled result");

  // Stall the input only while a byte is held
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid)
    else $error("input stalled with empty input register");

  // Indefinite length always reports an all-ones length
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_indefinite) |-> (&content_length))
    else $error("indefinite result without all-ones length");

  // Oversized length of length reports a zero, definite length
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_LEN_LONG) |-> (content_length == '0 && !is_indefinite))
    else $error("length-too-long result carries a length");

endmodule
